/* hw/rtl/beacon_frame_device_table_unit_assert.svh */
// Assertion macros used by the beacon frame device table checker.
`ifndef BEACON_FRAME_DEVICE_TABLE_UNIT_ASSERT_SVH
`define BEACON_FRAME_DEVICE_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFDT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFDT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bfdt_pkg.sv */
// Types, constants and codes for the beacon frame device table.
`timescale 1ns / 1ps

package bfdt_pkg;

  // Table geometry
  localparam int TABLE_SLOTS = 16;
  localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int SEL_W       = 4;
  localparam int CMP_W       = (CNT_W > SEL_W) ? CNT_W : SEL_W;

  // Frame layout
  localparam logic [7:0] HDR_FIRST  = 8'h59;  // 'Y'
  localparam logic [7:0] HDR_SECOND = 8'h51;  // 'Q'
  localparam int FRAME_LEN     = 14;
  localparam int FRAME_BODY    = FRAME_LEN - 2;
  localparam int PAYLOAD_BYTES = 8;
  localparam int POS_W         = $clog2(FRAME_BODY);
  localparam int BODY_W        = (FRAME_BODY - 1) * 8;

  typedef enum logic {
    OP_RX_BYTE   = 1'b0,
    OP_READ_SLOT = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    RESP_INSERTED   = 3'd0,
    RESP_UPDATED    = 3'd1,
    RESP_DROPPED    = 3'd2,
    RESP_SLOT_VALID = 3'd3,
    RESP_SLOT_EMPTY = 3'd4
  } resp_kind_t;

  typedef enum logic [1:0] {
    PH_SEEK_Y,
    PH_SEEK_Q,
    PH_BODY
  } hunt_phase_t;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_READ,
    TS_WALK,
    TS_CMP
  } tbl_state_t;

  typedef struct packed {
    logic [7:0]                   dev_type;
    logic [15:0]                  dev_id;
    logic [7:0]                   strength;
    logic [PAYLOAD_BYTES*8-1:0]   data;
  } dev_entry_t;

  localparam int ENTRY_W = $bits(dev_entry_t);

  typedef struct packed {
    logic       done;
    dev_entry_t entry;
  } frame_evt_t;

  typedef struct packed {
    logic             valid;
    logic [SEL_W-1:0] sel;
  } slot_req_t;

  typedef struct packed {
    logic       strobe;
    resp_kind_t kind;
    logic [3:0] slot;
    dev_entry_t entry;
    logic [4:0] count;
  } result_t;

endpackage

/* hw/rtl/bfdt_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module bfdt_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/bfdt_framer.sv */
// Header hunt and frame body collection for received radio bytes.
`timescale 1ns / 1ps

module bfdt_framer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_valid,
  input  logic [7:0]            rx_byte,
  output bfdt_pkg::frame_evt_t  evt
);

  bfdt_pkg::hunt_phase_t             phase_r, phase_nxt;
  logic [bfdt_pkg::POS_W-1:0]        pos_r, pos_nxt;
  logic [bfdt_pkg::BODY_W-1:0]       body_r, body_nxt;
  logic                              last_byte;

  assign last_byte = (pos_r == bfdt_pkg::POS_W'(bfdt_pkg::FRAME_BODY - 1));

  // Next hunt phase
  always_comb begin
    phase_nxt = phase_r;
    if (byte_valid) begin
      unique case (phase_r)
        bfdt_pkg::PH_SEEK_Y: begin
          phase_nxt = (rx_byte == bfdt_pkg::HDR_FIRST) ? bfdt_pkg::PH_SEEK_Q
                                                       : bfdt_pkg::PH_SEEK_Y;
        end
        bfdt_pkg::PH_SEEK_Q: begin
          // a repeated Y keeps waiting for Q
          if (rx_byte == bfdt_pkg::HDR_SECOND) begin
            phase_nxt = bfdt_pkg::PH_BODY;
          end else if (rx_byte != bfdt_pkg::HDR_FIRST) begin
            phase_nxt = bfdt_pkg::PH_SEEK_Y;
          end
        end
        bfdt_pkg::PH_BODY: begin
          if (last_byte) begin
            phase_nxt = bfdt_pkg::PH_SEEK_Y;
          end
        end
        default: begin
          phase_nxt = bfdt_pkg::PH_SEEK_Y;
        end
      endcase
    end
  end

  // Position and body bytes
  always_comb begin
    pos_nxt  = pos_r;
    body_nxt = body_r;
    if (byte_valid) begin
      if (phase_r == bfdt_pkg::PH_SEEK_Q && rx_byte == bfdt_pkg::HDR_SECOND) begin
        pos_nxt = '0;
      end else if (phase_r == bfdt_pkg::PH_BODY) begin
        if (last_byte) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_r + bfdt_pkg::POS_W'(1);
          body_nxt[pos_r*8 +: 8] = rx_byte;
        end
      end
    end
  end

  // Frame completion event; the last byte comes straight from the input
  always_comb begin
    evt.done           = byte_valid && (phase_r == bfdt_pkg::PH_BODY) && last_byte;
    evt.entry.dev_type = body_r[7:0];
    evt.entry.dev_id   = {body_r[23:16], body_r[15:8]};
    evt.entry.strength = body_r[31:24];
    evt.entry.data     = {rx_byte, body_r[bfdt_pkg::BODY_W-1:32]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bfdt_pkg::PH_SEEK_Y;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    body_r <= body_nxt;
  end

endmodule

/* hw/rtl/bfdt_table.sv */
// Device table engine: slot reads, id search, update and append on one RAM.
`timescale 1ns / 1ps

module bfdt_table (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bfdt_pkg::frame_evt_t  frame_in,
  input  bfdt_pkg::slot_req_t   req,
  output logic                  busy,
  output bfdt_pkg::result_t     res
);

  bfdt_pkg::tbl_state_t           state_r, state_nxt;
  logic [bfdt_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [bfdt_pkg::CNT_W-1:0]     count_r, count_nxt;
  bfdt_pkg::dev_entry_t           frame_r, frame_nxt;
  bfdt_pkg::result_t              res_r, res_nxt;

  logic                           ram_we, ram_re;
  logic [bfdt_pkg::IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [bfdt_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
  bfdt_pkg::dev_entry_t           rd_entry, upd_entry;

  logic                           sel_held;
  logic                           more;
  logic                           hit;
  logic                           full;
  logic                           place;

  assign rd_entry = bfdt_pkg::dev_entry_t'(ram_rdata);
  assign sel_held = bfdt_pkg::CMP_W'(req.sel) < bfdt_pkg::CMP_W'(count_r);
  assign more     = (bfdt_pkg::CNT_W'(idx_r) + bfdt_pkg::CNT_W'(1)) < count_r;
  assign hit      = (rd_entry.dev_id == frame_r.dev_id);
  assign full     = (count_r == bfdt_pkg::CNT_W'(bfdt_pkg::TABLE_SLOTS));

  // Matched entry keeps its type, takes the new strength and payload
  always_comb begin
    upd_entry          = rd_entry;
    upd_entry.strength = frame_r.strength;
    upd_entry.data     = frame_r.data;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfdt_pkg::TS_IDLE: begin
        if (req.valid && sel_held) begin
          state_nxt = bfdt_pkg::TS_READ;
        end else if (frame_in.done) begin
          state_nxt = bfdt_pkg::TS_WALK;
        end
      end
      bfdt_pkg::TS_READ: begin
        state_nxt = bfdt_pkg::TS_IDLE;
      end
      bfdt_pkg::TS_WALK: begin
        state_nxt = (count_r == '0) ? bfdt_pkg::TS_IDLE : bfdt_pkg::TS_CMP;
      end
      bfdt_pkg::TS_CMP: begin
        if (hit || !more) begin
          state_nxt = bfdt_pkg::TS_IDLE;
        end
      end
      default: begin
        state_nxt = bfdt_pkg::TS_IDLE;
      end
    endcase
  end

  // RAM control, table bookkeeping and result formation
  always_comb begin
    ram_re     = 1'b0;
    ram_raddr  = idx_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r;
    ram_wdata  = frame_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    frame_nxt  = frame_r;
    place      = 1'b0;
    res_nxt    = res_r;
    res_nxt.strobe = 1'b0;

    unique case (state_r)
      bfdt_pkg::TS_IDLE: begin
        if (req.valid) begin
          if (sel_held) begin
            // fetch the slot; the READ state reports it
            ram_re    = 1'b1;
            ram_raddr = bfdt_pkg::IDX_W'(req.sel);
            idx_nxt   = bfdt_pkg::IDX_W'(req.sel);
          end else begin
            res_nxt.strobe = 1'b1;
            res_nxt.kind   = bfdt_pkg::RESP_SLOT_EMPTY;
            res_nxt.slot   = req.sel;
            res_nxt.entry  = '0;
            res_nxt.count  = 5'(count_r);
          end
        end else if (frame_in.done) begin
          frame_nxt = frame_in.entry;
          idx_nxt   = '0;
        end
      end
      bfdt_pkg::TS_READ: begin
        res_nxt.strobe = 1'b1;
        res_nxt.kind   = bfdt_pkg::RESP_SLOT_VALID;
        res_nxt.slot   = 4'(idx_r);
        res_nxt.entry  = rd_entry;
        res_nxt.count  = 5'(count_r);
      end
      bfdt_pkg::TS_WALK: begin
        if (count_r == '0) begin
          place = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = '0;
        end
      end
      bfdt_pkg::TS_CMP: begin
        if (hit) begin
          // write back the refreshed entry
          ram_we         = 1'b1;
          ram_waddr      = idx_r;
          ram_wdata      = upd_entry;
          res_nxt.strobe = 1'b1;
          res_nxt.kind   = bfdt_pkg::RESP_UPDATED;
          res_nxt.slot   = 4'(idx_r);
          res_nxt.entry  = upd_entry;
          res_nxt.count  = 5'(count_r);
        end else if (more) begin
          // advance the walk, one entry per cycle
          idx_nxt   = idx_r + bfdt_pkg::IDX_W'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_r + bfdt_pkg::IDX_W'(1);
        end else begin
          place = 1'b1;
        end
      end
      default: begin
        place = 1'b0;
      end
    endcase

    // No match found: append, or drop when the table is full
    if (place) begin
      res_nxt.strobe = 1'b1;
      res_nxt.entry  = frame_r;
      if (full) begin
        res_nxt.kind  = bfdt_pkg::RESP_DROPPED;
        res_nxt.slot  = '0;
        res_nxt.count = 5'(count_r);
      end else begin
        ram_we        = 1'b1;
        ram_waddr     = bfdt_pkg::IDX_W'(count_r);
        ram_wdata     = frame_r;
        count_nxt     = count_r + bfdt_pkg::CNT_W'(1);
        res_nxt.kind  = bfdt_pkg::RESP_INSERTED;
        res_nxt.slot  = 4'(count_r);
        res_nxt.count = 5'(count_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bfdt_pkg::TS_IDLE;
      count_r       <= '0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
    end
  end

  // Hold the result register; the strobe drops while reset is asserted
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    frame_r      <= frame_nxt;
    res_r.strobe <= rst_n && res_nxt.strobe;
    res_r.kind   <= res_nxt.kind;
    res_r.slot   <= res_nxt.slot;
    res_r.entry  <= res_nxt.entry;
    res_r.count  <= res_nxt.count;
  end

  bfdt_ram #(
    .WIDTH (bfdt_pkg::ENTRY_W),
    .DEPTH (bfdt_pkg::TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy = (state_r != bfdt_pkg::TS_IDLE);
  assign res  = res_r;

endmodule

/* hw/rtl/beacon_frame_device_table_unit.sv */
// Top level of the beacon frame receiver with its device table.
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low. A received byte
// that does not finish a frame gives no result and leaves busy low. A read of
// an empty or absent slot is answered without busy; a read of a held slot
// holds busy for the table RAM read. The byte that finishes a frame holds busy
// while the table walks and compares the held entries one by one, up to and
// including a match (at most the held count): the id search reads one entry
// per cycle through the single read port of the table RAM. Each result
// appears on the out_ ports for exactly one cycle, in the cycle after the work
// that produced it, marked by out_strobe; the receiver cannot stall it, so
// take it then.
module beacon_frame_device_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [7:0]  in_rx_byte,
  input  logic [3:0]  in_slot_select,
  output logic        out_strobe,
  output logic [2:0]  out_response_kind,
  output logic [3:0]  out_slot,
  output logic [7:0]  out_device_type,
  output logic [15:0] out_device_id,
  output logic [7:0]  out_signal_strength,
  output logic [63:0] out_payload,
  output logic [4:0]  out_device_count
);

  logic                  accept;
  logic                  byte_valid;
  bfdt_pkg::frame_evt_t  frame_evt;
  bfdt_pkg::slot_req_t   slot_req;
  bfdt_pkg::result_t     res;

  // Split accepted transactions into bytes and slot reads
  assign accept         = start && !busy;
  assign byte_valid     = accept && (in_operation == bfdt_pkg::OP_RX_BYTE);
  assign slot_req.valid = accept && (in_operation == bfdt_pkg::OP_READ_SLOT);
  assign slot_req.sel   = in_slot_select;

  bfdt_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .rx_byte    (in_rx_byte),
    .evt        (frame_evt)
  );

  bfdt_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .frame_in (frame_evt),
    .req      (slot_req),
    .busy     (busy),
    .res      (res)
  );

  // Drive result ports from the output register
  assign out_strobe          = res.strobe;
  assign out_response_kind   = res.kind;
  assign out_slot            = res.slot;
  assign out_device_type     = res.entry.dev_type;
  assign out_device_id       = res.entry.dev_id;
  assign out_signal_strength = res.entry.strength;
  assign out_payload         = res.entry.data;
  assign out_device_count    = res.count;

endmodule

/* hw/rtl/bfdt_checker.sv */
// Port-level assertion checker for the beacon frame device table, with its bind.
`timescale 1ns / 1ps
`include "beacon_frame_device_table_unit_assert.svh"

module bfdt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_operation,
  input logic        out_strobe,
  input logic [2:0]  out_response_kind,
  input logic [3:0]  out_slot,
  input logic [7:0]  out_device_type,
  input logic [15:0] out_device_id,
  input logic [7:0]  out_signal_strength,
  input logic [63:0] out_payload,
  input logic [4:0]  out_device_count
);

  // An empty slot reads back as all zero fields
  `BFDT_ASSERT_IMP(a_empty_zero, clk, rst_n, out_strobe && out_response_kind == bfdt_pkg::RESP_SLOT_EMPTY, out_device_type == '0 && out_device_id == '0 && out_signal_strength == '0 && out_payload == '0, "empty slot result carries data")

  // The held count never exceeds the table size
  `BFDT_ASSERT_IMP(a_count_bound, clk, rst_n, out_strobe, out_device_count <= 5'(bfdt_pkg::TABLE_SLOTS), "device count beyond table size")

  // A dropped frame means a full table and reports slot zero
  `BFDT_ASSERT_IMP(a_drop_full, clk, rst_n, out_strobe && out_response_kind == bfdt_pkg::RESP_DROPPED, out_slot == '0 && out_device_count == 5'(bfdt_pkg::TABLE_SLOTS), "drop without a full table")

  // A slot read either answers next cycle or keeps the block busy
  `BFDT_ASSERT_NXT(a_read_answers, clk, rst_n, start && !busy && in_operation == bfdt_pkg::OP_READ_SLOT, busy || out_strobe, "slot read produced no result")

endmodule

bind beacon_frame_device_table_unit bfdt_checker u_bfdt_checker (.*);

/* tb/testbench.sv */
// Self-checking testbench for the beacon frame device table unit.
`timescale 1ns / 1ps

module testbench;
  import bfdt_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CALM_TAIL    = 200;
  localparam int ID_POOL      = 24;
  localparam int DIR_ROWS     = 22;
  localparam int PRINT_CAP    = 100;

  // One status transaction as seen on the out_ ports
  typedef struct {
    resp_kind_t kind;
    logic [3:0] slot;
    dev_entry_t entry;
    logic [4:0] count;
  } status_t;

  // One planned input transaction with its idle gap in front
  typedef struct {
    op_t        op;
    logic [7:0] rx;
    logic [3:0] sel;
    int         gap;
    bit         typed;
    logic [4:0] typed_count;
  } stim_t;

  // Directed row; a typed row expects an empty slot with the given count
  typedef struct packed {
    op_t        op;
    logic [7:0] rx;
    logic [3:0] sel;
    logic       typed;
    logic [4:0] count;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [7:0]  in_rx_byte;
  logic [3:0]  in_slot_select;
  logic        out_strobe;
  logic [2:0]  out_response_kind;
  logic [3:0]  out_slot;
  logic [7:0]  out_device_type;
  logic [15:0] out_device_id;
  logic [7:0]  out_signal_strength;
  logic [63:0] out_payload;
  logic [4:0]  out_device_count;

  beacon_frame_device_table_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_rx_byte          (in_rx_byte),
    .in_slot_select      (in_slot_select),
    .out_strobe          (out_strobe),
    .out_response_kind   (out_response_kind),
    .out_slot            (out_slot),
    .out_device_type     (out_device_type),
    .out_device_id       (out_device_id),
    .out_signal_strength (out_signal_strength),
    .out_payload         (out_payload),
    .out_device_count    (out_device_count)
  );

  // Directed stimulus: header hunt, header inside a frame, extremes, reads
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{OP_READ_SLOT, 8'h00,      4'd0,  1'b1, 5'd0},
    '{OP_READ_SLOT, 8'hFF,      4'd15, 1'b1, 5'd0},
    '{OP_RX_BYTE,   HDR_FIRST,  4'd0,  1'b0, 5'd0},
    '{OP_RX_BYTE,   8'h00,      4'd0,  1'b0, 5'd0},
    '{OP_RX_BYTE,   HDR_FIRST,  4'd0,  1'b0, 5'd0},
    '{OP_RX_BYTE,   HDR_FIRST,  4'd0,  1'b0, 5'd0},
    '{OP_RX_BYTE,   HDR_SECOND, 4'd0,  1'b0, 5'd0},
    '{OP_RX_BYTE,   8'hFF,      4'd0,  1'b0, 5'd0},
    '{OP_RX_BYTE,   8'hFF,      4'd0,  1'b0, 5'd0},
    '{OP_READ_SLOT, 8'h00,      4'd7,  1'b1, 5'd0},
    '{OP_RX_BYTE,   8'hFF,      4'd0,  1'b0, 5'd0},
    '{OP_RX_BYTE,   8'h00,      4'd0,  1'b0, 5'd0},
    '{OP_RX_BYTE,   HDR_FIRST,  4'd0,  1'b0, 5'd0},
    '{OP_RX_BYTE,   HDR_SECOND, 4'd0,  1'b0, 5'd0},
    '{OP_RX_BYTE,   8'h00,      4'd0,  1'b0, 5'd0},
    '{OP_RX_BYTE,   8'hFF,      4'd0,  1'b0, 5'd0},
    '{OP_RX_BYTE,   8'h80,      4'd0,  1'b0, 5'd0},
    '{OP_RX_BYTE,   8'h01,      4'd0,  1'b0, 5'd0},
    '{OP_RX_BYTE,   8'h7F,      4'd0,  1'b0, 5'd0},
    '{OP_RX_BYTE,   8'hFE,      4'd0,  1'b0, 5'd0},
    '{OP_READ_SLOT, 8'h00,      4'd0,  1'b0, 5'd0},
    '{OP_READ_SLOT, 8'h00,      4'd1,  1'b1, 5'd1}
  };

  // Predictor state
  hunt_phase_t model_phase;
  int          model_pos;
  logic [7:0]  model_body [FRAME_BODY];
  logic [4:0]  model_held;
  dev_entry_t  model_table [TABLE_SLOTS];

  stim_t       stim_plan [$];
  status_t     status_queue [$];
  logic [15:0] id_pool [ID_POOL];
  int          planned;
  bit          calm;
  int          accept_idx;
  int          cycle_count;
  int          error_count;
  bit          took_item;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Step the predictor by one accepted transaction
  task automatic predict_status(input op_t op, input logic [7:0] rx, input logic [3:0] sel,
                                output bit produced, output status_t st);
    dev_entry_t f;
    bit         hit;
    int         k;
    produced = 1'b0;
    st.kind  = RESP_SLOT_EMPTY;
    st.slot  = sel;
    st.entry = '0;
    st.count = model_held;
    if (op == OP_READ_SLOT) begin
      produced = 1'b1;
      if (sel < model_held) begin
        st.kind  = RESP_SLOT_VALID;
        st.entry = model_table[sel];
      end
    end else begin
      case (model_phase)
        PH_BODY: begin
          model_body[model_pos] = rx;
          model_pos++;
          if (model_pos == FRAME_BODY) begin
            model_phase = PH_SEEK_Y;
            model_pos   = 0;
            f.dev_type  = model_body[0];
            f.dev_id    = {model_body[2], model_body[1]};
            f.strength  = model_body[3];
            for (k = 0; k < PAYLOAD_BYTES; k++) f.data[8*k +: 8] = model_body[4+k];
            produced = 1'b1;
            hit      = 1'b0;
            // Search held entries; first id match wins and keeps its type
            for (k = 0; k < int'(model_held); k++) begin
              if (!hit && model_table[k].dev_id == f.dev_id) begin
                hit = 1'b1;
                model_table[k].strength = f.strength;
                model_table[k].data     = f.data;
                st.kind  = RESP_UPDATED;
                st.slot  = k[3:0];
                st.entry = model_table[k];
              end
            end
            if (!hit) begin
              st.entry = f;
              if (model_held >= TABLE_SLOTS) begin
                st.kind = RESP_DROPPED;
                st.slot = '0;
              end else begin
                st.kind = RESP_INSERTED;
                st.slot = model_held[3:0];
                model_table[model_held[3:0]] = f;
                model_held++;
              end
            end
            st.count = model_held;
          end
        end
        PH_SEEK_Q: begin
          if (rx == HDR_SECOND) begin
            model_phase = PH_BODY;
            model_pos   = 0;
          end else if (rx != HDR_FIRST) begin
            model_phase = PH_SEEK_Y;
          end
        end
        default: begin
          model_phase = (rx == HDR_FIRST) ? PH_SEEK_Q : PH_SEEK_Y;
        end
      endcase
    end
  endtask

  // Append one transaction to the plan and pick its idle gap
  task automatic plan_item(input op_t op, input logic [7:0] rx, input logic [3:0] sel,
                           input bit counts);
    stim_t s;
    s.op          = op;
    s.rx          = rx;
    s.sel         = sel;
    s.typed       = 1'b0;
    s.typed_count = '0;
    s.gap         = 0;
    if (!calm && planned < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 5) == 0)
      s.gap = $urandom_range(1, 12);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    if (counts) planned++;
    stim_plan.push_back(s);
  endtask

  // Plan a well-formed frame with random content, reads mixed in now and then
  task automatic plan_frame(input logic [15:0] id);
    logic [7:0] bytes [FRAME_LEN];
    int         k;
    bytes[0] = HDR_FIRST;
    bytes[1] = HDR_SECOND;
    bytes[2] = $urandom_range(0, 255);
    bytes[3] = id[7:0];
    bytes[4] = id[15:8];
    for (k = 5; k < FRAME_LEN; k++) bytes[k] = $urandom_range(0, 255);
    for (k = 0; k < FRAME_LEN; k++) begin
      if ($urandom_range(0, 11) == 0)
        plan_item(OP_READ_SLOT, $urandom_range(0, 255), $urandom_range(0, 15), 1'b1);
      plan_item(OP_RX_BYTE, bytes[k], $urandom_range(0, 15), 1'b1);
    end
  endtask

  // Report one mismatch and count it
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %0h expected %0h",
               cycle_count, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Sample the handshake and the status strobe
  always @(posedge clk) begin : monitor
    bit      produced;
    status_t st;
    status_t want;
    cycle_count++;
    took_item = 1'b0;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("beacon_frame_device_table_unit regression: fail");
      $finish;
    end else if (rst_n) begin
      // Compare a status transaction against the oldest expectation
      if (out_strobe !== 1'b0) begin
        if (status_queue.size() == 0) begin
          report_mismatch("status with nothing pending", out_response_kind, '0);
        end else begin
          want = status_queue.pop_front();
          check_field("response_kind", out_response_kind, want.kind);
          check_field("slot", out_slot, want.slot);
          check_field("device_type", out_device_type, want.entry.dev_type);
          check_field("device_id", out_device_id, want.entry.dev_id);
          check_field("signal_strength", out_signal_strength, want.entry.strength);
          check_field("payload", out_payload, want.entry.data);
          check_field("device_count", out_device_count, want.count);
        end
      end
      // Predict the accepted transaction
      if (start === 1'b1 && busy === 1'b0) begin
        took_item = 1'b1;
        predict_status(op_t'(in_operation), in_rx_byte, in_slot_select, produced, st);
        if (accept_idx < stim_plan.size() && stim_plan[accept_idx].typed) begin
          st.kind  = RESP_SLOT_EMPTY;
          st.slot  = in_slot_select;
          st.entry = '0;
          st.count = stim_plan[accept_idx].typed_count;
        end
        if (produced) status_queue.push_back(st);
        accept_idx++;
      end
    end
  end

  initial begin : driver
    int         i;
    int         n;
    int         pick;
    logic [7:0] b;
    logic [15:0] id;
    start          = 1'b0;
    in_operation   = OP_RX_BYTE;
    in_rx_byte     = '0;
    in_slot_select = '0;
    rst_n          = 1'b0;
    cycle_count    = 0;
    error_count    = 0;
    accept_idx     = 0;
    planned        = 0;
    calm           = 1'b0;
    took_item      = 1'b0;
    model_phase    = PH_SEEK_Y;
    model_pos      = 0;
    model_held     = '0;
    for (i = 0; i < FRAME_BODY; i++) model_body[i] = '0;
    for (i = 0; i < TABLE_SLOTS; i++) model_table[i] = '0;

    // Walk the directed table
    for (i = 0; i < DIR_ROWS; i++) begin
      plan_item(directed_rows[i].op, directed_rows[i].rx, directed_rows[i].sel, 1'b0);
      stim_plan[stim_plan.size()-1].typed       = directed_rows[i].typed;
      stim_plan[stim_plan.size()-1].typed_count = directed_rows[i].count;
    end

    // Id pool larger than the table, so it fills and then drops
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (i = 2; i < ID_POOL; i++) id_pool[i] = $urandom_range(0, 65535);

    // Random part: mostly frames, then reads, broken headers and noise
    while (planned < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 7) == 0) id = $urandom_range(0, 65535);
        else id = id_pool[$urandom_range(0, ID_POOL-1)];
        plan_frame(id);
      end else if (pick < 82) begin
        plan_item(OP_READ_SLOT, $urandom_range(0, 255), $urandom_range(0, 15), 1'b1);
      end else if (pick < 92) begin
        n = $urandom_range(1, 3);
        repeat (n) plan_item(OP_RX_BYTE, HDR_FIRST, $urandom_range(0, 15), 1'b1);
        b = $urandom_range(0, 255);
        if (b == HDR_SECOND) b = ~b;
        plan_item(OP_RX_BYTE, b, $urandom_range(0, 15), 1'b1);
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) plan_item(OP_RX_BYTE, $urandom_range(0, 255), $urandom_range(0, 15), 1'b0);
      end
    end

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Drive each transaction and hold it until the handshake takes it
    for (i = 0; i < stim_plan.size(); i++) begin
      if (stim_plan[i].gap > 0) begin
        start = 1'b0;
        repeat (stim_plan[i].gap) @(negedge clk);
      end
      in_operation   = stim_plan[i].op;
      in_rx_byte     = stim_plan[i].rx;
      in_slot_select = stim_plan[i].sel;
      start          = 1'b1;
      @(negedge clk);
      while (!took_item) @(negedge clk);
    end
    start = 1'b0;

    // Drain outstanding status, then let the block settle
    while (status_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("beacon_frame_device_table_unit regression: pass");
    end else begin
      $display("beacon_frame_device_table_unit regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/bfdt_pkg.sv
hw/rtl/bfdt_ram.sv
hw/rtl/bfdt_framer.sv
hw/rtl/bfdt_table.sv
hw/rtl/beacon_frame_device_table_unit.sv
hw/rtl/bfdt_checker.sv
tb/testbench.sv
